// ===== sv/glcd_pkg.sv =====
// ----------------------------------------------------------------------------
// glcd_pkg
// Shared types and constants for the graphic LCD column controller.
// ----------------------------------------------------------------------------
`default_nettype none

package glcd_pkg;

  localparam int unsigned RAM_BYTES_DEF = 512;
  localparam int unsigned COLS          = 64;
  localparam int unsigned COL_W         = 6;
  localparam int unsigned PAGE_W        = 3;
  localparam int unsigned WIN_W         = 16;

  // Access kinds in cmd[9:8]
  localparam logic [1:0] ACC_READ   = 2'b11;
  localparam logic [1:0] ACC_STATUS = 2'b10;
  localparam logic [1:0] ACC_WRITE  = 2'b01;
  localparam logic [1:0] ACC_INSTR  = 2'b00;

  // Instruction patterns
  localparam logic [7:0] INS_START_MASK = 8'hC0;
  localparam logic [7:0] INS_PAGE_MASK  = 8'hB8;
  localparam logic [7:0] INS_COL_MASK   = 8'h40;
  localparam logic [7:0] INS_POWER_MASK = 8'h3E;

  localparam logic [7:0]       STATUS_OFF     = 8'h20;
  localparam logic [WIN_W-1:0] WINDOW_RESET   = 16'd2;
  localparam logic [WIN_W-1:0] TICKS_SAT      = 16'hFFFF;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic       op;
    logic [9:0] cmd;
  } glcd_in_t;

  typedef struct packed {
    logic [7:0] data;
    logic       rejected;
    logic       changed;
    logic       display_on;
    logic [5:0] start_line;
  } glcd_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OUT
  } glcd_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear_we;
    logic accept;
  } glcd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;
  } glcd_stat_t;

endpackage

`default_nettype wire

// ===== sv/graphic_lcd_column_controller.sv =====
// ----------------------------------------------------------------------------
// graphic_lcd_column_controller
// Column driver of a 64x64 graphic LCD with 8-page by 64-column display RAM.
// ----------------------------------------------------------------------------
// After reset the block clears its display RAM, one byte per cycle, over all
// RAM_BYTES (512) addresses; in_stall stays high during that pass. Then
// each input beat is accepted in ST_IDLE, which updates the registers and
// reads or writes the RAM, and its result is handed out of the result
// register in ST_OUT until out_stall is low, with in_stall high meanwhile. The
// busy window register may be written at any time the block is idle; the
// write takes effect on the next accepted beat.
`default_nettype none

module graphic_lcd_column_controller #(
  parameter int unsigned RAM_BYTES = glcd_pkg::RAM_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire glcd_pkg::glcd_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output glcd_pkg::glcd_out_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [15:0]         cfg_data
);
  import glcd_pkg::*;

  glcd_cmd_t  cmd;
  glcd_stat_t stat;

  assign cfg_ready = 1'b1;

  glcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  glcd_dp #(
    .RAM_BYTES (RAM_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data)
  );

endmodule

`default_nettype wire

// ===== sv/glcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// glcd_ctrl
// Sequencer: RAM clearing pass after reset, item accept and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module glcd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire glcd_pkg::glcd_stat_t stat,
  output glcd_pkg::glcd_cmd_t      cmd
);
  import glcd_pkg::*;

  glcd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    cmd.clear_we = 1'b0;
    cmd.accept   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/glcd_dp.sv =====
// ----------------------------------------------------------------------------
// glcd_dp
// Datapath: display RAM, address/mode registers, busy timer, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module glcd_dp #(
  parameter int unsigned RAM_BYTES = glcd_pkg::RAM_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire glcd_pkg::glcd_cmd_t  cmd,
  output glcd_pkg::glcd_stat_t      stat,
  input  wire glcd_pkg::glcd_in_t   in_data,
  output glcd_pkg::glcd_out_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_data
);
  import glcd_pkg::*;

  localparam int unsigned ADDR_W = $clog2(RAM_BYTES);

  logic [7:0] ram [RAM_BYTES];
  logic [7:0] ram_q_r;

  logic [ADDR_W-1:0] clr_addr_r;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              power_r, power_nxt;
  logic [5:0]        line_r, line_nxt;
  logic [WIN_W-1:0]  ticks_r, ticks_nxt;
  logic [WIN_W-1:0]  window_r;

  logic [7:0] data_r, data_nxt;
  logic       rej_r, rej_nxt;
  logic       chg_r, chg_nxt;
  logic       is_rd_r, is_rd_nxt;

  logic              ram_we;
  logic [COL_W-1:0]  col_prev;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        ins;

  assign ins      = in_data.cmd[7:0];
  assign col_prev = col_r - COL_W'(1);
  assign wr_addr  = ADDR_W'({page_r, col_r});
  assign rd_addr  = ADDR_W'({page_r, col_prev});

  assign stat.clear_last = (clr_addr_r == ADDR_W'(RAM_BYTES - 1));

  always_comb begin
    page_nxt  = page_r;
    col_nxt   = col_r;
    power_nxt = power_r;
    line_nxt  = line_r;
    ticks_nxt = ticks_r;
    data_nxt  = 8'd0;
    rej_nxt   = 1'b0;
    chg_nxt   = 1'b0;
    is_rd_nxt = 1'b0;
    ram_we    = 1'b0;
    priority if (in_data.op == OP_TICK) begin
      if (ticks_r != TICKS_SAT) begin
        ticks_nxt = ticks_r + WIN_W'(1);
      end
    end else if (ticks_r < window_r) begin
      rej_nxt = 1'b1;
    end else begin
      ticks_nxt = '0;
      priority if (in_data.cmd[9:8] == ACC_READ) begin
        is_rd_nxt = 1'b1;
        col_nxt   = col_r + COL_W'(1);
      end else if (in_data.cmd[9:8] == ACC_STATUS) begin
        // busy bit is always clear once a command is taken
        data_nxt = power_r ? 8'd0 : STATUS_OFF;
      end else if (in_data.cmd[9:8] == ACC_WRITE) begin
        ram_we  = 1'b1;
        col_nxt = col_r + COL_W'(1);
        chg_nxt = 1'b1;
      end else if ((ins & INS_START_MASK) == INS_START_MASK) begin
        line_nxt = ins[5:0];
        chg_nxt  = (ins[5:0] != line_r);
      end else if ((ins & INS_PAGE_MASK) == INS_PAGE_MASK) begin
        page_nxt = ins[2:0];
        chg_nxt  = (ins[2:0] != page_r);
      end else if ((ins & INS_COL_MASK) == INS_COL_MASK) begin
        col_nxt = ins[5:0];
        chg_nxt = (ins[5:0] != col_r);
      end else if ((ins & INS_POWER_MASK) == INS_POWER_MASK) begin
        power_nxt = ins[0];
        chg_nxt   = (ins[0] != power_r);
      end else begin
        // unknown instruction: only restarts the busy timer
        chg_nxt = 1'b0;
      end
    end
  end

  // Display RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_we) begin
      ram[clr_addr_r] <= 8'd0;
    end else if (cmd.accept && ram_we) begin
      ram[wr_addr] <= ins;
    end
    if (cmd.accept) begin
      ram_q_r <= ram[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      page_r     <= '0;
      col_r      <= '0;
      power_r    <= 1'b0;
      line_r     <= '0;
      ticks_r    <= TICKS_SAT;
      window_r   <= WINDOW_RESET;
    end else begin
      if (cmd.clear_we) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (cfg_we) begin
        window_r <= cfg_data;
      end
      if (cmd.accept) begin
        page_r  <= page_nxt;
        col_r   <= col_nxt;
        power_r <= power_nxt;
        line_r  <= line_nxt;
        ticks_r <= ticks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data_r  <= data_nxt;
      rej_r   <= rej_nxt;
      chg_r   <= chg_nxt;
      is_rd_r <= is_rd_nxt;
    end
  end

  assign out_data.data       = is_rd_r ? ram_q_r : data_r;
  assign out_data.rejected   = rej_r;
  assign out_data.changed    = chg_r;
  assign out_data.display_on = power_r;
  assign out_data.start_line = line_r;

endmodule

`default_nettype wire
